### hdl/cbr_pkg.sv
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared types and constants for the cubic root bisection block.
// ----------------------------------------------------------------------------
`default_nettype none

package cbr_pkg;

   localparam int DEF_VALUE_WIDTH   = 32;
   localparam int DEF_FRACTION_BITS = 16;

   localparam int END_WIDTH       = 28;
   localparam int STATUS_WIDTH    = 2;
   localparam int ITER_WIDTH      = 8;
   localparam int TOL_WIDTH       = 32;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [TOL_WIDTH-1:0]  TOL_RESET      = TOL_WIDTH'(66);
   localparam logic [ITER_WIDTH-1:0] MAX_ITER_RESET = ITER_WIDTH'(100);

   // polynomial coefficients, integer parts
   localparam int POLY_C2  = 2;
   localparam int POLY_C10 = 10;
   localparam int POLY_C20 = 20;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TOLERANCE      = 1'b0,
      CSR_MAX_ITERATIONS = 1'b1
   } csr_index_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_ROOT      = 2'd0,
      STATUS_SAME_SIGN = 2'd1,
      STATUS_LIMIT     = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_NONE    = 4'd0,
      OP_LOAD    = 4'd1,
      OP_SAVE_FA = 4'd2,
      OP_SAVE_FB = 4'd3,
      OP_MID     = 4'd4,
      OP_ADD2    = 4'd5,
      OP_MUL_LO  = 4'd6,
      OP_MUL_HI  = 4'd7,
      OP_FIX     = 4'd8,
      OP_ADD10   = 4'd9,
      OP_SUB20   = 4'd10,
      OP_UPDATE  = 4'd11,
      OP_OUT     = 4'd12
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic same_sign;
      logic converged;
      logic at_limit;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### hdl/cbr_regs.sv
// ----------------------------------------------------------------------------
// cbr_regs
// Configuration registers: tolerance and iteration limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cbr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [cbr_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output logic [cbr_pkg::TOL_WIDTH-1:0]             tolerance,
   output logic [cbr_pkg::ITER_WIDTH-1:0]            max_iterations
);
   import cbr_pkg::*;

   logic [TOL_WIDTH-1:0]  tolerance_ff, tolerance_in;
   logic [ITER_WIDTH-1:0] max_iter_ff, max_iter_in;
   csr_index_type         index;

   assign csr_ready = 1'b1;
   assign index     = csr_index_type'(csr_index);

   always_comb begin
      tolerance_in = tolerance_ff;
      max_iter_in  = max_iter_ff;
      if (csr_valid) begin
         unique case (index)
            CSR_TOLERANCE:      tolerance_in = csr_data[TOL_WIDTH-1:0];
            CSR_MAX_ITERATIONS: max_iter_in  = csr_data[ITER_WIDTH-1:0];
            default:            tolerance_in = tolerance_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOL_RESET;
         max_iter_ff  <= MAX_ITER_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
         max_iter_ff  <= max_iter_in;
      end
   end

   assign tolerance      = tolerance_ff;
   assign max_iterations = max_iter_ff;

endmodule

`default_nettype wire

### hdl/cbr_dp.sv
// ----------------------------------------------------------------------------
// cbr_dp
// Datapath: interval registers, Horner evaluation on a shared half-width
// multiplier, midpoint, decision flags and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_dp #(
   parameter int VALUE_WIDTH   = cbr_pkg::DEF_VALUE_WIDTH,
   parameter int FRACTION_BITS = cbr_pkg::DEF_FRACTION_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire cbr_pkg::cmd_type                        cmd,
   output cbr_pkg::dp_status_type                       status,
   input  wire logic signed [cbr_pkg::END_WIDTH-1:0]    req_left_end,
   input  wire logic signed [cbr_pkg::END_WIDTH-1:0]    req_right_end,
   input  wire logic [cbr_pkg::TOL_WIDTH-1:0]           tolerance,
   input  wire logic [cbr_pkg::ITER_WIDTH-1:0]          max_iterations,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_stall,
   output logic signed [cbr_pkg::END_WIDTH-1:0]         rsp_root,
   output logic [cbr_pkg::STATUS_WIDTH-1:0]             rsp_status,
   output logic [cbr_pkg::ITER_WIDTH-1:0]               rsp_iterations
);
   import cbr_pkg::*;

   localparam int VW   = VALUE_WIDTH;
   localparam int WIDE = 2 * VW + 2;
   localparam int AW   = 2 * VW;
   localparam int HALF = (VW + 1) / 2;
   localparam int PW   = VW + HALF;
   localparam int CW   = (VW > TOL_WIDTH) ? VW : TOL_WIDTH;

   localparam logic signed [WIDE-1:0] VMAX_W = WIDE'({1'b0, {(VW-1){1'b1}}});
   localparam logic signed [WIDE-1:0] VMIN_W = ~VMAX_W;
   localparam logic signed [VW-1:0]   VMAX_V = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0]   VMIN_V = {1'b1, {(VW-1){1'b0}}};

   localparam logic signed [WIDE-1:0] K_TWO = WIDE'(POLY_C2) << FRACTION_BITS;
   localparam logic signed [WIDE-1:0] K_TEN = WIDE'(POLY_C10) << FRACTION_BITS;
   localparam logic signed [WIDE-1:0] K_TWENTY = WIDE'(POLY_C20) << FRACTION_BITS;

   function automatic logic signed [WIDE-1:0] ext_fn(input logic signed [VW-1:0] v);
      logic signed [WIDE-1:0] r;
      r = {{(WIDE-VW){v[VW-1]}}, v};
      return r;
   endfunction

   function automatic logic signed [VW-1:0] sat_fn(input logic signed [WIDE-1:0] v);
      logic signed [VW-1:0] r;
      if (v > VMAX_W) begin
         r = VMAX_V;
      end else if (v < VMIN_W) begin
         r = VMIN_V;
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

   logic signed [VW-1:0]   a_ff, a_in, b_ff, b_in, x_ff, x_in, t_ff, t_in;
   logic                   fa_pos_ff, fa_pos_in, fa_neg_ff, fa_neg_in;
   logic                   fb_pos_ff, fb_pos_in, fb_neg_ff, fb_neg_in;
   logic [AW-1:0]          acc_ff, acc_in;
   logic                   prod_neg_ff, prod_neg_in;
   logic [ITER_WIDTH-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [END_WIDTH-1:0] rsp_root_ff, rsp_root_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [ITER_WIDTH-1:0]  rsp_iter_ff, rsp_iter_in;

   logic signed [WIDE-1:0] left_w, right_w, sum_w, x_w;
   logic [VW-1:0]          p_mag, x_mag, t_mag;
   logic [HALF-1:0]        chunk;
   logic [PW-1:0]          prod;
   logic signed [AW-1:0]   sval, shifted;
   logic                   t_pos, t_neg;
   logic [ITER_WIDTH-1:0]  limit_eff;

   assign left_w  = {{(WIDE-END_WIDTH){req_left_end[END_WIDTH-1]}}, req_left_end};
   assign right_w = {{(WIDE-END_WIDTH){req_right_end[END_WIDTH-1]}}, req_right_end};
   assign sum_w   = ext_fn(a_ff) + ext_fn(b_ff);
   assign x_w     = ext_fn(x_ff);

   assign t_neg = t_ff[VW-1];
   assign t_pos = !t_ff[VW-1] && (t_ff != '0);
   assign t_mag = t_neg ? VW'(-t_ff) : t_ff;
   assign p_mag = t_mag;
   assign x_mag = x_ff[VW-1] ? VW'(-x_ff) : x_ff;

   assign chunk = (cmd.op == OP_MUL_LO) ? x_mag[HALF-1:0] : HALF'(x_mag >> HALF);
   assign prod  = PW'(p_mag) * PW'(chunk);

   assign sval    = prod_neg_ff ? AW'(-acc_ff) : acc_ff;
   assign shifted = sval >>> FRACTION_BITS;

   assign limit_eff = (max_iterations == '0) ? ITER_WIDTH'(1) : max_iterations;

   assign status.same_sign = (fa_pos_ff && t_pos) || (fa_neg_ff && t_neg);
   assign status.converged = CW'(t_mag) <= CW'(tolerance);
   assign status.at_limit  = count_ff == limit_eff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      a_in        = a_ff;
      b_in        = b_ff;
      x_in        = x_ff;
      t_in        = t_ff;
      fa_pos_in   = fa_pos_ff;
      fa_neg_in   = fa_neg_ff;
      fb_pos_in   = fb_pos_ff;
      fb_neg_in   = fb_neg_ff;
      acc_in      = acc_ff;
      prod_neg_in = prod_neg_ff;
      count_in    = count_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_status_in = rsp_status_ff;
      rsp_iter_in   = rsp_iter_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            a_in     = sat_fn(left_w);
            b_in     = sat_fn(right_w);
            x_in     = sat_fn(left_w);
            count_in = '0;
         end
         OP_SAVE_FA: begin
            fa_pos_in = t_pos;
            fa_neg_in = t_neg;
            x_in      = b_ff;
         end
         OP_SAVE_FB: begin
            fb_pos_in = t_pos;
            fb_neg_in = t_neg;
         end
         OP_MID: begin
            x_in     = VW'(sum_w >>> 1);
            count_in = count_ff + ITER_WIDTH'(1);
         end
         OP_ADD2: t_in = sat_fn(x_w + K_TWO);
         OP_MUL_LO: begin
            acc_in      = AW'(prod);
            prod_neg_in = t_ff[VW-1] ^ x_ff[VW-1];
         end
         OP_MUL_HI: acc_in = acc_ff + (AW'(prod) << HALF);
         OP_FIX:    t_in = sat_fn({{(WIDE-AW){shifted[AW-1]}}, shifted});
         OP_ADD10:  t_in = sat_fn(ext_fn(t_ff) + K_TEN);
         OP_SUB20:  t_in = sat_fn(ext_fn(t_ff) - K_TWENTY);
         OP_UPDATE: begin
            if ((t_pos && fa_pos_ff) || (t_neg && fa_neg_ff)) begin
               a_in      = x_ff;
               fa_pos_in = t_pos;
               fa_neg_in = t_neg;
            end else if ((t_pos && fb_pos_ff) || (t_neg && fb_neg_ff)) begin
               b_in      = x_ff;
               fb_pos_in = t_pos;
               fb_neg_in = t_neg;
            end
         end
         OP_OUT: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = cmd.code;
            rsp_iter_in   = count_ff;
            if (cmd.code == STATUS_SAME_SIGN) begin
               rsp_root_in = '0;
               rsp_iter_in = '0;
            end else begin
               rsp_root_in = x_w[END_WIDTH-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      x_ff          <= x_in;
      t_ff          <= t_in;
      fa_pos_ff     <= fa_pos_in;
      fa_neg_ff     <= fa_neg_in;
      fb_pos_ff     <= fb_pos_in;
      fb_neg_ff     <= fb_neg_in;
      acc_ff        <= acc_in;
      prod_neg_ff   <= prod_neg_in;
      count_ff      <= count_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_status_ff <= rsp_status_in;
      rsp_iter_ff   <= rsp_iter_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root       = rsp_root_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_iterations = rsp_iter_ff;

   a_same_sign_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_SAME_SIGN) |->
         (rsp_root_ff == '0) && (rsp_iter_ff == '0))
      else $error("same-sign result carries nonzero root or count");

   a_root_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_ROOT) |-> (rsp_iter_ff != '0))
      else $error("root found with no midpoint evaluated");

endmodule

`default_nettype wire

### hdl/cbr_ctrl.sv
// ----------------------------------------------------------------------------
// cbr_ctrl
// Sequencer: endpoint evaluation, sign check, bisection loop and result
// hand-off, issuing one datapath command per cycle while not waiting for a request or for a free output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbr_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   output cbr_pkg::cmd_type                   cmd,
   input  wire cbr_pkg::dp_status_type        status
);
   import cbr_pkg::*;

   typedef enum logic [14:0] {
      ST_IDLE    = 15'h0001,
      ST_ADD2    = 15'h0002,
      ST_MLO1    = 15'h0004,
      ST_MHI1    = 15'h0008,
      ST_FIX1    = 15'h0010,
      ST_ADD10   = 15'h0020,
      ST_MLO2    = 15'h0040,
      ST_MHI2    = 15'h0080,
      ST_FIX2    = 15'h0100,
      ST_SUB20   = 15'h0200,
      ST_SAVE_FA = 15'h0400,
      ST_ENDS    = 15'h0800,
      ST_MID     = 15'h1000,
      ST_DECIDE  = 15'h2000,
      ST_DONE    = 15'h4000
   } state_type;

   typedef enum logic [2:0] {
      PH_A   = 3'b001,
      PH_B   = 3'b010,
      PH_MID = 3'b100
   } phase_type;

   state_type  state_ff, state_in;
   phase_type  phase_ff, phase_in;
   status_type code_ff, code_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      code_in  = code_ff;
      cmd.op   = OP_NONE;
      cmd.code = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               phase_in = PH_A;
               state_in = ST_ADD2;
            end
         end
         ST_ADD2: begin
            cmd.op   = OP_ADD2;
            state_in = ST_MLO1;
         end
         ST_MLO1: begin
            cmd.op   = OP_MUL_LO;
            state_in = ST_MHI1;
         end
         ST_MHI1: begin
            cmd.op   = OP_MUL_HI;
            state_in = ST_FIX1;
         end
         ST_FIX1: begin
            cmd.op   = OP_FIX;
            state_in = ST_ADD10;
         end
         ST_ADD10: begin
            cmd.op   = OP_ADD10;
            state_in = ST_MLO2;
         end
         ST_MLO2: begin
            cmd.op   = OP_MUL_LO;
            state_in = ST_MHI2;
         end
         ST_MHI2: begin
            cmd.op   = OP_MUL_HI;
            state_in = ST_FIX2;
         end
         ST_FIX2: begin
            cmd.op   = OP_FIX;
            state_in = ST_SUB20;
         end
         ST_SUB20: begin
            cmd.op = OP_SUB20;
            unique case (phase_ff)
               PH_A:    state_in = ST_SAVE_FA;
               PH_B:    state_in = ST_ENDS;
               PH_MID:  state_in = ST_DECIDE;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SAVE_FA: begin
            cmd.op   = OP_SAVE_FA;
            phase_in = PH_B;
            state_in = ST_ADD2;
         end
         ST_ENDS: begin
            cmd.op = OP_SAVE_FB;
            if (status.same_sign) begin
               code_in  = STATUS_SAME_SIGN;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            cmd.op   = OP_MID;
            phase_in = PH_MID;
            state_in = ST_ADD2;
         end
         ST_DECIDE: begin
            if (status.converged) begin
               code_in  = STATUS_ROOT;
               state_in = ST_DONE;
            end else begin
               cmd.op = OP_UPDATE;
               if (status.at_limit) begin
                  code_in  = STATUS_LIMIT;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MID;
               end
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_A;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   a_out_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |-> status.out_free)
      else $error("result written while output register still held");

   a_accept_starts_eval: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> (state_ff == ST_ADD2) && (phase_ff == PH_A))
      else $error("accepted transaction did not start endpoint evaluation");

endmodule

`default_nettype wire

### hdl/cubic_root_bisection.sv
// ----------------------------------------------------------------------------
// cubic_root_bisection
// Bisection search for a root of x^3 + 2x^2 + 10x - 20 on a fixed-point
// interval, with same-sign and iteration-limit reporting.
// ----------------------------------------------------------------------------
// same-sign endpoints end after both endpoints are evaluated; otherwise n midpoints
//   are evaluated, n <= max_iterations (n <= 1 when max_iterations is 0)
// each evaluation of f makes two products, each done in two passes
//   of one shared value-by-half-width multiplier; next transaction accepted
//   the cycle after the result is loaded into the output register
// reset clears control state; tolerance returns to 66, max_iterations to 100
`default_nettype none

module cubic_root_bisection #(
   parameter int VALUE_WIDTH   = cbr_pkg::DEF_VALUE_WIDTH,
   parameter int FRACTION_BITS = cbr_pkg::DEF_FRACTION_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [cbr_pkg::END_WIDTH-1:0]  req_left_end,
   input  wire logic signed [cbr_pkg::END_WIDTH-1:0]  req_right_end,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [cbr_pkg::END_WIDTH-1:0]       rsp_root,
   output logic [cbr_pkg::STATUS_WIDTH-1:0]           rsp_status,
   output logic [cbr_pkg::ITER_WIDTH-1:0]             rsp_iterations,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cbr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [cbr_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import cbr_pkg::*;

   cmd_type               cmd;
   dp_status_type         status;
   logic [TOL_WIDTH-1:0]  tolerance;
   logic [ITER_WIDTH-1:0] max_iterations;

   cbr_regs u_regs (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .tolerance      (tolerance),
      .max_iterations (max_iterations)
   );

   cbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   cbr_dp #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_left_end   (req_left_end),
      .req_right_end  (req_right_end),
      .tolerance      (tolerance),
      .max_iterations (max_iterations),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_root       (rsp_root),
      .rsp_status     (rsp_status),
      .rsp_iterations (rsp_iterations)
   );

endmodule

`default_nettype wire
